// ----- src/mwms_pkg.sv -----
// shared constants and width helpers for the moving window mean and std dev block
package mwms_pkg;

  localparam int SMP_W          = 16;
  localparam int OUT_W          = 16;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam logic [CFG_W-1:0] WL_RESET = 7'd10;

  // ring index width
  function automatic int idx_w(int wm);
    return $clog2(wm);
  endfunction

  // width that holds a length from 1 to wm
  function automatic int len_w(int wm);
    return $clog2(wm + 1);
  endfunction

  // signed running sum width
  function automatic int sum_w(int wm);
    return SMP_W + $clog2(wm);
  endfunction

  // unsigned running square sum width
  function automatic int sq_w(int wm);
    return 2 * SMP_W - 1 + $clog2(wm);
  endfunction

  // front to back item: valid flag, sum, square sum
  function automatic int item_w(int wm);
    return 1 + sum_w(wm) + sq_w(wm);
  endfunction

endpackage

// ----- src/moving_window_mean_stddev.sv -----
// Sliding window mean and standard deviation over signed 16-bit samples. The front part
// takes a sample only while idle and its queue is not full, does the ring read-modify-write,
// then the running sum and sum of squares update, and takes no new sample before that update;
// it hands the sums through a two-entry queue to the back part. The back part runs a
// bit-serial square root over half the variance numerator width (22 bits at the default
// window maximum of 64) and two serial dividers by the window length over a 22-bit dividend;
// an item before the window is full goes straight to the done state there. The back part's
// iterative square root and division set the sustained rate. A finished result waits in
// an output register while the next item is worked on. Writing the window length clears
// the window; the length is clamped to 1..WindowMax.
module moving_window_mean_stddev #(
  parameter int WindowMax = mwms_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mwms_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic signed [mwms_pkg::SMP_W-1:0] sample_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mwms_pkg::OUT_W-1:0] mean_o,
  output logic [mwms_pkg::OUT_W-1:0]        std_dev_o,
  output logic                              valid_res_o
);
  import mwms_pkg::*;

  localparam int LW = len_w(WindowMax);
  localparam int IW = item_w(WindowMax);

  logic [LW-1:0] len;
  logic          f_push;
  logic          f_full;
  logic [IW-1:0] f_item;
  logic          b_pop;
  logic          b_empty;
  logic [IW-1:0] b_item;

  // sample intake and running sums
  mwms_front #(.WindowMax(WindowMax)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .sample_i    (sample_i),
    .len_o       (len),
    .q_push_o    (f_push),
    .q_full_i    (f_full),
    .q_item_o    (f_item)
  );

  // decoupling queue
  mwms_fifo #(.Width(IW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_item),
    .full_o  (f_full),
    .pop_i   (b_pop),
    .empty_o (b_empty),
    .data_o  (b_item)
  );

  // statistics
  mwms_back #(.WindowMax(WindowMax)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len),
    .q_empty_i   (b_empty),
    .q_pop_o     (b_pop),
    .q_item_i    (b_item),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .mean_o      (mean_o),
    .std_dev_o   (std_dev_o),
    .valid_res_o (valid_res_o)
  );

endmodule

// ----- src/mwms_front.sv -----
// front part: window register, sample ring and running sums
module mwms_front #(
  parameter int WindowMax = mwms_pkg::WINDOW_MAX_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [mwms_pkg::CFG_W-1:0]                  cfg_wdata_i,
  input  logic                                        push_i,
  output logic                                        full_o,
  input  logic signed [mwms_pkg::SMP_W-1:0]           sample_i,
  output logic [mwms_pkg::len_w(WindowMax)-1:0]       len_o,
  output logic                                        q_push_o,
  input  logic                                        q_full_i,
  output logic [mwms_pkg::item_w(WindowMax)-1:0]      q_item_o
);
  import mwms_pkg::*;

  localparam int AW = idx_w(WindowMax);
  localparam int LW = len_w(WindowMax);
  localparam int SW = sum_w(WindowMax);
  localparam int QW = sq_w(WindowMax);
  localparam int PW = 2 * SMP_W - 1;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } fstate_e;

  // clamp the register value to 1..WindowMax
  function automatic logic [LW-1:0] eff_len(logic [CFG_W-1:0] wl);
    logic [LW-1:0] l;
    if (wl == '0) begin
      l = LW'(1);
    end else if (int'(wl) > WindowMax) begin
      l = LW'(WindowMax);
    end else begin
      l = LW'(wl);
    end
    return l;
  endfunction

  fstate_e                 state_q;
  logic [CFG_W-1:0]        wl_q;
  logic [AW-1:0]           wp_q;
  logic [LW-1:0]           fill_q;
  logic signed [SW-1:0]    sum_q;
  logic [QW-1:0]           sq_q;
  logic [WindowMax-1:0]    vbit_q;
  logic                    oldv_q;
  logic signed [SMP_W-1:0] x_q;
  logic signed [SMP_W-1:0] old_q;
  logic [PW-1:0]           x2_q;
  logic signed [SMP_W-1:0] mem [WindowMax];

  logic [LW-1:0]           len;
  logic                    accept;
  logic [LW-1:0]           wp_inc;
  logic [AW-1:0]           wp_nxt;
  logic signed [2*SMP_W-1:0] x2_full;
  logic signed [SMP_W-1:0] old_eff;
  logic signed [2*SMP_W-1:0] o2_full;
  logic signed [SW-1:0]    sum_d;
  logic [QW-1:0]           sq_d;
  logic [LW-1:0]           fill_d;
  logic                    vld;

  assign len    = eff_len(wl_q);
  assign len_o  = len;
  assign full_o = (state_q != F_IDLE) | q_full_i;
  assign accept = push_i & ~full_o;

  // next ring position wraps at the window length
  assign wp_inc = LW'(wp_q) + LW'(1);
  assign wp_nxt = (wp_inc >= len) ? '0 : wp_inc[AW-1:0];

  assign x2_full = sample_i * sample_i;

  // sum update with the replaced sample taken out
  assign old_eff = oldv_q ? old_q : '0;
  assign o2_full = old_eff * old_eff;
  assign sum_d   = sum_q - SW'(old_eff) + SW'(x_q);
  assign sq_d    = sq_q - QW'(o2_full[PW-1:0]) + QW'(x2_q);
  assign fill_d  = (fill_q < len) ? fill_q + LW'(1) : fill_q;
  assign vld     = (fill_d == len);

  assign q_push_o = (state_q == F_UPD);
  assign q_item_o = {vld, sum_d, sq_d};

  // ring memory, read of the old entry and write of the new one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wp_nxt] <= sample_i;
      old_q       <= mem[wp_nxt];
      x_q         <= sample_i;
      x2_q        <= x2_full[PW-1:0];
    end
  end

  // control, sums and entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wl_q    <= WL_RESET;
      wp_q    <= AW'(eff_len(WL_RESET) - LW'(1));
      fill_q  <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      vbit_q  <= '0;
      oldv_q  <= 1'b0;
    end else if (cfg_we_i) begin
      state_q <= F_IDLE;
      wl_q    <= cfg_wdata_i;
      wp_q    <= AW'(eff_len(cfg_wdata_i) - LW'(1));
      fill_q  <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      vbit_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            wp_q           <= wp_nxt;
            oldv_q         <= vbit_q[wp_nxt];
            vbit_q[wp_nxt] <= 1'b1;
            state_q        <= F_UPD;
          end
        end
        F_UPD: begin
          sum_q   <= sum_d;
          sq_q    <= sq_d;
          fill_q  <= fill_d;
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mwms_fifo.sv -----
// two-entry queue between the front and back parts
module mwms_fifo #(
  parameter int Width = mwms_pkg::item_w(mwms_pkg::WINDOW_MAX_DEF)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  import mwms_pkg::*;

  logic [Width-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/mwms_back.sv -----
// back part: variance numerator, bitwise square root and two serial dividers
module mwms_back #(
  parameter int WindowMax = mwms_pkg::WINDOW_MAX_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [mwms_pkg::len_w(WindowMax)-1:0]   len_i,
  input  logic                                    q_empty_i,
  output logic                                    q_pop_o,
  input  logic [mwms_pkg::item_w(WindowMax)-1:0]  q_item_i,
  output logic                                    res_empty_o,
  input  logic                                    res_pop_i,
  output logic signed [mwms_pkg::OUT_W-1:0]       mean_o,
  output logic [mwms_pkg::OUT_W-1:0]              std_dev_o,
  output logic                                    valid_res_o
);
  import mwms_pkg::*;

  localparam int LW = len_w(WindowMax);
  localparam int SW = sum_w(WindowMax);
  localparam int QW = sq_w(WindowMax);
  localparam int IW = item_w(WindowMax);
  localparam int NW = (QW + LW > 2 * SW) ? QW + LW : 2 * SW;
  localparam int NE = NW + (NW % 2);
  localparam int RW = NE / 2;
  localparam int DW = (RW > SW) ? RW : SW;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_DIFF = 6'b000100,
    B_SQRT = 6'b001000,
    B_DIV  = 6'b010000,
    B_DONE = 6'b100000
  } bstate_e;

  bstate_e              st_q;
  logic                 vld_q;
  logic                 neg_q;
  logic [SW-1:0]        mag_q;
  logic [QW-1:0]        sq_q;
  logic [NW-1:0]        p1_q;
  logic [NW-1:0]        p2_q;
  logic [NE-1:0]        num_q;
  logic [RW+1:0]        srem_q;
  logic [RW-1:0]        root_q;
  logic [CW-1:0]        cnt_q;
  logic [DW-1:0]        dvd_m_q;
  logic [DW-1:0]        dvd_s_q;
  logic [LW-1:0]        rem_m_q;
  logic [LW-1:0]        rem_s_q;
  logic                 res_vld_q;
  logic signed [OUT_W-1:0] mean_q;
  logic [OUT_W-1:0]     sd_q;
  logic                 valid_q;

  logic signed [SW-1:0] in_sum;
  logic [QW+LW-1:0]     p1_w;
  logic [2*SW-1:0]      p2_w;
  logic [RW+3:0]        st_t;
  logic [RW+3:0]        st_trial;
  logic                 st_ge;
  logic [RW-1:0]        root_d;
  logic [LW:0]          dm_t;
  logic [LW:0]          ds_t;
  logic                 dm_ge;
  logic                 ds_ge;
  logic                 load_res;

  assign in_sum  = q_item_i[IW-2 -: SW];
  assign q_pop_o = (st_q == B_IDLE) & ~q_empty_i;

  assign p1_w = sq_q * len_i;
  assign p2_w = mag_q * mag_q;

  // one root digit per cycle
  assign st_t     = {srem_q, num_q[NE-1 -: 2]};
  assign st_trial = {2'b00, root_q, 2'b01};
  assign st_ge    = (st_t >= st_trial);
  assign root_d   = {root_q[RW-2:0], st_ge};

  // one quotient bit per cycle for each divider
  assign dm_t  = {rem_m_q, dvd_m_q[DW-1]};
  assign ds_t  = {rem_s_q, dvd_s_q[DW-1]};
  assign dm_ge = (dm_t >= {1'b0, len_i});
  assign ds_ge = (ds_t >= {1'b0, len_i});

  assign load_res = (st_q == B_DONE) & (~res_vld_q | res_pop_i);

  assign res_empty_o = ~res_vld_q;
  assign mean_o      = mean_q;
  assign std_dev_o   = sd_q;
  assign valid_res_o = valid_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        vld_q <= q_item_i[IW-1];
        neg_q <= in_sum[SW-1];
        mag_q <= in_sum[SW-1] ? SW'(-in_sum) : SW'(in_sum);
        sq_q  <= q_item_i[QW-1:0];
      end
      B_MUL: begin
        p1_q <= NW'(p1_w);
        p2_q <= NW'(p2_w);
      end
      B_DIFF: begin
        num_q  <= NE'((p1_q >= p2_q) ? p1_q - p2_q : p2_q - p1_q);
        srem_q <= '0;
        root_q <= '0;
      end
      B_SQRT: begin
        num_q  <= {num_q[NE-3:0], 2'b00};
        srem_q <= st_ge ? (RW+2)'(st_t - st_trial) : (RW+2)'(st_t);
        root_q <= root_d;
        if (cnt_q == CW'(RW - 1)) begin
          dvd_s_q <= DW'(root_d);
          dvd_m_q <= DW'(mag_q);
          rem_s_q <= '0;
          rem_m_q <= '0;
        end
      end
      B_DIV: begin
        rem_m_q <= dm_ge ? LW'(dm_t - {1'b0, len_i}) : LW'(dm_t);
        rem_s_q <= ds_ge ? LW'(ds_t - {1'b0, len_i}) : LW'(ds_t);
        dvd_m_q <= {dvd_m_q[DW-2:0], dm_ge};
        dvd_s_q <= {dvd_s_q[DW-2:0], ds_ge};
      end
      B_DONE: begin
        if (load_res) begin
          valid_q <= vld_q;
          if (vld_q) begin
            mean_q <= neg_q ? OUT_W'(-dvd_m_q[OUT_W-1:0]) : dvd_m_q[OUT_W-1:0];
            sd_q   <= ((dvd_s_q >> OUT_W) != '0) ? '1 : dvd_s_q[OUT_W-1:0];
          end else begin
            mean_q <= '0;
            sd_q   <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (res_pop_i & res_vld_q) res_vld_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          if (!q_empty_i) st_q <= q_item_i[IW-1] ? B_MUL : B_DONE;
        end
        B_MUL:  st_q <= B_DIFF;
        B_DIFF: begin
          cnt_q <= '0;
          st_q  <= B_SQRT;
        end
        B_SQRT: begin
          if (cnt_q == CW'(RW - 1)) begin
            cnt_q <= '0;
            st_q  <= B_DIV;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        B_DIV: begin
          if (cnt_q == CW'(DW - 1)) begin
            cnt_q <= '0;
            st_q  <= B_DONE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        B_DONE: begin
          if (load_res) begin
            res_vld_q <= 1'b1;
            st_q      <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mwms_checker.sv -----
// port level checks for the moving window mean and std dev block, with its bind
module mwms_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic                              push,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [mwms_pkg::OUT_W-1:0] mean_o,
  input logic [mwms_pkg::OUT_W-1:0]        std_dev_o,
  input logic                              valid_res_o
);
  import mwms_pkg::*;

  // a waiting result holds until its transfer
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(mean_o) && $stable(std_dev_o)
      && $stable(valid_res_o))
    else $error("result changed before transfer");

  // results before the window fills are all zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !valid_res_o |-> mean_o == '0 && std_dev_o == '0)
    else $error("invalid result not zero");

  // the front is busy on the cycle after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && !cfg_we_i |=> full)
    else $error("input taken on back-to-back cycles");

endmodule

bind moving_window_mean_stddev mwms_checker u_mwms_checker (.*);

// ----- tb/tb_moving_window_mean_stddev.sv -----
// self-checking testbench for the sliding window mean and standard deviation block
module tb_moving_window_mean_stddev;
  import mwms_pkg::*;

  localparam int WMAX     = WINDOW_MAX_DEF;
  localparam int MAX_IDLE = 17;
  localparam int SETTLE   = 120;
  localparam int N_RAND   = 1350;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [SMP_W-1:0]   val;
    logic [OUT_W-1:0]   mean;
    logic [OUT_W-1:0]   sd;
    logic               vld;
  } row_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] sd;
    logic             vld;
  } stats_t;

  // directed rows: extremes, invalid fill, clamped lengths, clear on write
  localparam int N_DIR = 22;
  localparam row_t DIR_TAB [N_DIR] = '{
    '{ROW_CHECKED_ITEM, 16'h8000, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h7fff, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h0001, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'hffff, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h5555, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'haaaa, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h0100, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'hff00, 16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM,         16'h0064, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,          16'h0001, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h8000, 16'h8000, 16'h0000, 1'b1},
    '{ROW_CHECKED_ITEM, 16'h7fff, 16'h7fff, 16'h0000, 1'b1},
    '{ROW_CFG,          16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'hffff, 16'hffff, 16'h0000, 1'b1},
    '{ROW_CFG,          16'h0002, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h8000, 16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM,         16'h7fff, 16'h0000, 16'h0000, 1'b0},
    '{ROW_ITEM,         16'h8000, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,          16'h007f, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h8000, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CHECKED_ITEM, 16'h7fff, 16'h0000, 16'h0000, 1'b0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    push = 1'b0;
  logic                    full;
  logic signed [SMP_W-1:0] sample_i = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [OUT_W-1:0] mean_o;
  logic [OUT_W-1:0]        std_dev_o;
  logic                    valid_res_o;

  moving_window_mean_stddev u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .empty       (empty),
    .pop         (pop),
    .mean_o      (mean_o),
    .std_dev_o   (std_dev_o),
    .valid_res_o (valid_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // window model state
  int          win_len;
  longint      win_ring [WMAX];
  int          wr_pos;
  int          fill_cnt;
  longint      win_sum;
  longint      win_sq_sum;

  stats_t      pending_stats [$];
  int          err_cnt = 0;
  bit          burst_mode = 1'b0;
  bit          stim_done = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // clamp the length and clear the window
  function automatic void set_window_length(logic [CFG_W-1:0] v);
    int l;
    l = int'(v);
    if (l < 1) l = 1;
    if (l > WMAX) l = WMAX;
    win_len = l;
    for (int i = 0; i < WMAX; i++) win_ring[i] = 0;
    wr_pos = l - 1;
    fill_cnt = 0;
    win_sum = 0;
    win_sq_sum = 0;
  endfunction

  // slide the window by one sample and work out mean and std dev
  function automatic stats_t slide_window(logic signed [SMP_W-1:0] s);
    stats_t          r;
    longint          x;
    longint          old;
    longint unsigned s1abs;
    longint unsigned s1sq;
    longint unsigned ls2;
    longint unsigned num;
    longint unsigned sd;
    longint          m;
    x = longint'(s);
    wr_pos = wr_pos + 1;
    if (wr_pos >= win_len) wr_pos = 0;
    old = win_ring[wr_pos];
    win_sum = win_sum - old + x;
    win_sq_sum = win_sq_sum - old * old + x * x;
    win_ring[wr_pos] = x;
    if (fill_cnt < win_len) fill_cnt++;
    r = '0;
    if (fill_cnt == win_len) begin
      s1abs = (win_sum < 0) ? longint'(-win_sum) : longint'(win_sum);
      s1sq = s1abs * s1abs;
      ls2 = longint'(win_len) * win_sq_sum;
      num = (ls2 >= s1sq) ? ls2 - s1sq : s1sq - ls2;
      m = win_sum / longint'(win_len);
      sd = int_sqrt(num) / longint'(win_len);
      if (sd > 64'hffff) sd = 64'hffff;
      r.mean = m[OUT_W-1:0];
      r.sd = sd[OUT_W-1:0];
      r.vld = 1'b1;
    end
    return r;
  endfunction

  function automatic int draw_idle();
    return burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // send one sample; push stays high if the next transfer follows at once
  task automatic send_sample(logic [SMP_W-1:0] s, bit typed, stats_t typed_res);
    int     gap;
    stats_t p;
    gap = draw_idle();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    sample_i <= s;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    p = slide_window(s);
    pending_stats.push_back(typed ? typed_res : p);
    @(negedge clk_i);
  endtask

  // wait for the block to drain, then write the length register
  task automatic write_length(logic [CFG_W-1:0] v);
    push <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_window_length(v);
  endtask

  function automatic logic [SMP_W-1:0] draw_sample(int style, logic [SMP_W-1:0] base);
    case (style)
      0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      1: return base + 16'($urandom_range(0, 6)) - 16'd3;
      2: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    stats_t           tr;
    int               n_sent;
    int               style;
    int               run_len;
    logic [SMP_W-1:0] base;
    logic [CFG_W-1:0] lens [8];
    lens = '{7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd3, 7'd33, 7'd10};
    set_window_length(WL_RESET);
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < N_DIR; i++) begin
      tr = '{mean: DIR_TAB[i].mean, sd: DIR_TAB[i].sd, vld: DIR_TAB[i].vld};
      case (DIR_TAB[i].kind)
        ROW_CFG: write_length(DIR_TAB[i].val[CFG_W-1:0]);
        ROW_CHECKED_ITEM: send_sample(DIR_TAB[i].val, 1'b1, tr);
        default: send_sample(DIR_TAB[i].val, 1'b0, tr);
      endcase
    end
    // random phases over several window lengths
    n_sent = 0;
    for (int ph = 0; n_sent < N_RAND; ph++) begin
      if (ph < 8) write_length(lens[ph]);
      else write_length($urandom_range(0, 1) ? 7'($urandom_range(1, 12))
                                              : 7'($urandom));
      burst_mode = (ph % 3 == 1);
      run_len = $urandom_range(60, 200);
      style = $urandom_range(0, 3);
      base = 16'($urandom);
      for (int k = 0; k < run_len && n_sent < N_RAND; k++) begin
        if ($urandom_range(0, 15) == 0) style = $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) burst_mode = !burst_mode;
        send_sample(draw_sample(style, base), 1'b0, tr);
        n_sent++;
      end
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // result side stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (!empty) break;
      end
      @(negedge clk_i);
    end
  end

  // compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_stats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result: mean=%0d sd=%0d valid=%0b",
                                    mean_o, std_dev_o, valid_res_o);
      end else begin
        want = pending_stats.pop_front();
        if (mean_o !== want.mean || std_dev_o !== want.sd || valid_res_o !== want.vld) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp mean=%0d sd=%0d valid=%0b, got mean=%0d sd=%0d valid=%0b",
                     $signed(want.mean), want.sd, want.vld, mean_o, std_dev_o, valid_res_o);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done && pending_stats.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (err_cnt == 0 && pending_stats.size() == 0) begin
      $display("tb_moving_window_mean_stddev: done, clean");
    end else begin
      $display("tb_moving_window_mean_stddev: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("tb_moving_window_mean_stddev: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/mwms_pkg.sv
src/mwms_front.sv
src/mwms_fifo.sv
src/mwms_back.sv
src/moving_window_mean_stddev.sv
src/mwms_checker.sv
tb/tb_moving_window_mean_stddev.sv
